// ===== rtl/core/hpr2_pkg.sv =====
// ----------------------------------------------------------------------------
// hpr2_pkg
// Shared types, constants and helpers of the Hermitian packed rank-2 update.
// ----------------------------------------------------------------------------
package hpr2_pkg;

  localparam int DEFAULT_MAX_ORDER = 64;
  localparam int DATA_W            = 32;
  localparam int ORDER_W           = 7;
  localparam int VIDX_W            = 6;
  localparam int CFG_IDX_W         = 2;
  localparam int QUEUE_DEPTH       = 2;
  // Accumulator width: four shifted products plus one Q16.16 term.
  localparam int ACC_W             = 50;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATRIX_ORDER = 2'd0,
    CFG_UPPER        = 2'd1,
    CFG_ALPHA_RE     = 2'd2,
    CFG_ALPHA_IM     = 2'd3
  } cfg_idx_t;

  // Product schedule of the shared multiplier: column factors, then update.
  typedef enum logic [3:0] {
    MUL_T1R_A = 4'd0,  MUL_T1R_B = 4'd1,  MUL_T1I_A = 4'd2,  MUL_T1I_B = 4'd3,
    MUL_T2R_A = 4'd4,  MUL_T2R_B = 4'd5,  MUL_T2I_A = 4'd6,  MUL_T2I_B = 4'd7,
    MUL_UR_A  = 4'd8,  MUL_UR_B  = 4'd9,  MUL_UR_C  = 4'd10, MUL_UR_D  = 4'd11,
    MUL_UI_A  = 4'd12, MUL_UI_B  = 4'd13, MUL_UI_C  = 4'd14, MUL_UI_D  = 4'd15
  } mul_step_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_TMUL, S_TDRN, S_TSAT, S_UMUL, S_UDRN, S_DONE
  } back_state_t;

  // Fixed part of one queued item; addresses travel beside it.
  typedef struct packed {
    logic                     is_load;
    logic                     diag;
    logic                     last;
    logic signed [DATA_W-1:0] x_re;
    logic signed [DATA_W-1:0] x_im;
    logic signed [DATA_W-1:0] y_re;
    logic signed [DATA_W-1:0] y_im;
    logic signed [DATA_W-1:0] ap_re;
    logic signed [DATA_W-1:0] ap_im;
  } q_data_t;

  // Saturate an accumulator to 32 bits.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] top;
    top = v[ACC_W-1:DATA_W-1];
    if ((&top) || (~|top)) begin
      return v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/core/hpr2_front.sv =====
// ----------------------------------------------------------------------------
// hpr2_front
// Accepts items, tracks the packed position and builds queue entries.
// ----------------------------------------------------------------------------
module hpr2_front #(
  parameter  int MAX_ORDER = hpr2_pkg::DEFAULT_MAX_ORDER,
  localparam int IdxW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic [hpr2_pkg::VIDX_W-1:0]          in_vec_index,
  input  logic signed [hpr2_pkg::DATA_W-1:0]   in_x_real,
  input  logic signed [hpr2_pkg::DATA_W-1:0]   in_x_imag,
  input  logic signed [hpr2_pkg::DATA_W-1:0]   in_y_real,
  input  logic signed [hpr2_pkg::DATA_W-1:0]   in_y_imag,
  input  logic signed [hpr2_pkg::DATA_W-1:0]   in_ap_real,
  input  logic signed [hpr2_pkg::DATA_W-1:0]   in_ap_imag,
  input  logic [hpr2_pkg::ORDER_W-1:0]         matrix_order,
  input  logic                                 upper_triangle,
  input  logic                                 restart,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output hpr2_pkg::q_data_t                    push_data,
  output logic [IdxW-1:0]                      push_addr_a,
  output logic [IdxW-1:0]                      push_addr_b
);
  import hpr2_pkg::*;

  localparam int OrdW = $clog2(MAX_ORDER + 1);

  logic [IdxW-1:0] col_r, col_nxt;
  logic [IdxW-1:0] row_r, row_nxt;
  logic [OrdW-1:0] n_eff, j_cur, i_cur, j_adv, i_adv;
  logic            accept, advance;

  // Effective order: zero acts as one, large values clamp to the store depth.
  always_comb begin
    if (matrix_order == '0) begin
      n_eff = OrdW'(1);
    end else if (32'(matrix_order) > 32'(MAX_ORDER)) begin
      n_eff = OrdW'(MAX_ORDER);
    end else begin
      n_eff = OrdW'(matrix_order);
    end
  end

  // Current position, clamped, and the position of the following element.
  always_comb begin
    j_cur = (OrdW'(col_r) >= n_eff) ? '0 : OrdW'(col_r);
    i_cur = (OrdW'(row_r) >= n_eff) ? j_cur : OrdW'(row_r);
    i_adv = i_cur;
    j_adv = j_cur;
    if (upper_triangle) begin
      if (i_cur < j_cur) begin
        i_adv = i_cur + OrdW'(1);
      end else begin
        i_adv = '0;
        j_adv = ((j_cur + OrdW'(1)) >= n_eff) ? '0 : j_cur + OrdW'(1);
      end
    end else begin
      if ((i_cur + OrdW'(1)) < n_eff) begin
        i_adv = i_cur + OrdW'(1);
      end else begin
        j_adv = ((j_cur + OrdW'(1)) >= n_eff) ? '0 : j_cur + OrdW'(1);
        i_adv = j_adv;
      end
    end
  end

  // Handshake: an out-of-range load is accepted and dropped.
  assign in_ready   = push_ready;
  assign accept     = in_valid && push_ready;
  assign push_valid = in_valid && (in_mode || (32'(in_vec_index) < 32'(MAX_ORDER)));
  assign advance    = accept && in_mode;

  // Entry contents.
  always_comb begin
    push_data.is_load = !in_mode;
    push_data.diag    = (i_cur == j_cur);
    push_data.last    = (i_cur == n_eff - OrdW'(1)) && (j_cur == n_eff - OrdW'(1));
    push_data.x_re    = in_x_real;
    push_data.x_im    = in_x_imag;
    push_data.y_re    = in_y_real;
    push_data.y_im    = in_y_imag;
    push_data.ap_re   = in_ap_real;
    push_data.ap_im   = in_ap_imag;
    if (in_mode) begin
      push_addr_a = IdxW'(j_cur);
      push_addr_b = IdxW'(i_cur);
    end else begin
      push_addr_a = IdxW'(in_vec_index);
      push_addr_b = IdxW'(in_vec_index);
    end
  end

  // Position counters; a shape write restarts the traversal.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (advance) begin
      col_nxt = IdxW'(j_adv);
      row_nxt = IdxW'(i_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== rtl/core/hpr2_queue.sv =====
// ----------------------------------------------------------------------------
// hpr2_queue
// Short FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module hpr2_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);
  import hpr2_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]    slot_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != CntW'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointer and fill bookkeeping.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (32'(wp_r) == QUEUE_DEPTH - 1) ? '0 : wp_r + PtrW'(1);
    end
    if (do_pop) begin
      rp_nxt = (32'(rp_r) == QUEUE_DEPTH - 1) ? '0 : rp_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/hpr2_back.sv =====
// ----------------------------------------------------------------------------
// hpr2_back
// Vector stores, shared multiplier sequencer and result register.
// ----------------------------------------------------------------------------
module hpr2_back #(
  parameter  int MAX_ORDER = hpr2_pkg::DEFAULT_MAX_ORDER,
  localparam int IdxW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  hpr2_pkg::q_data_t                    q_data,
  input  logic [IdxW-1:0]                      q_addr_a,
  input  logic [IdxW-1:0]                      q_addr_b,
  output logic                                 q_pop,
  input  logic signed [hpr2_pkg::DATA_W-1:0]   alpha_re,
  input  logic signed [hpr2_pkg::DATA_W-1:0]   alpha_im,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [hpr2_pkg::DATA_W-1:0]   out_real,
  output logic signed [hpr2_pkg::DATA_W-1:0]   out_imag,
  output logic                                 out_last_of_matrix
);
  import hpr2_pkg::*;

  localparam int EW = 2 * DATA_W;

  // Vector stores, entry is {real, imag}.
  logic [EW-1:0] x_mem [MAX_ORDER];
  logic [EW-1:0] y_mem [MAX_ORDER];
  logic [EW-1:0] xa_r, ya_r, xb_r, yb_r;

  back_state_t state_r, state_nxt;
  logic        wr_en, rd_en, issue, sat_t, load_out;
  logic        alpha_zero, col_zero;

  logic [3:0]  step_r, step_nxt;
  mul_step_t   tag_r;
  logic        pv_r;
  logic        diag_r, last_r;

  logic signed [DATA_W-1:0] op_a, op_b;
  logic signed [EW-1:0]     prod_r, prod_sh;
  logic signed [ACC_W-1:0]  qv;
  logic signed [ACC_W-1:0]  t1r_acc, t1i_acc, t2r_acc, t2i_acc, ur_acc, ui_acc;
  logic signed [DATA_W-1:0] t1r_r, t1i_r, t2r_r, t2i_r;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_re_r, out_im_r;
  logic                     out_last_r;

  assign alpha_zero = (alpha_re == '0) && (alpha_im == '0);
  assign col_zero   = (xa_r == '0) && (ya_r == '0);

  // Sequencer: next state and control strobes.
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    issue     = 1'b0;
    sat_t     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_data.is_load) begin
            wr_en = 1'b1;
          end else begin
            rd_en     = 1'b1;
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        state_nxt = (alpha_zero || col_zero) ? S_DONE : S_TMUL;
      end
      S_TMUL: begin
        issue = 1'b1;
        if (mul_step_t'(step_r) == MUL_T2I_B) begin
          state_nxt = S_TDRN;
        end
      end
      S_TDRN: begin
        state_nxt = S_TSAT;
      end
      S_TSAT: begin
        sat_t     = 1'b1;
        state_nxt = S_UMUL;
      end
      S_UMUL: begin
        issue = 1'b1;
        if (mul_step_t'(step_r) == MUL_UI_D) begin
          state_nxt = S_UDRN;
        end
      end
      S_UDRN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Store writes and registered reads at the column and row addresses.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[q_addr_a] <= {q_data.x_re, q_data.x_im};
      y_mem[q_addr_a] <= {q_data.y_re, q_data.y_im};
    end
    if (rd_en) begin
      xa_r <= x_mem[q_addr_a];
      ya_r <= y_mem[q_addr_a];
      xb_r <= x_mem[q_addr_b];
      yb_r <= y_mem[q_addr_b];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (mul_step_t'(step_r))
      MUL_T1R_A: begin op_a = alpha_re;           op_b = ya_r[EW-1:DATA_W]; end
      MUL_T1R_B: begin op_a = alpha_im;           op_b = ya_r[DATA_W-1:0];  end
      MUL_T1I_A: begin op_a = alpha_im;           op_b = ya_r[EW-1:DATA_W]; end
      MUL_T1I_B: begin op_a = alpha_re;           op_b = ya_r[DATA_W-1:0];  end
      MUL_T2R_A: begin op_a = alpha_re;           op_b = xa_r[EW-1:DATA_W]; end
      MUL_T2R_B: begin op_a = alpha_im;           op_b = xa_r[DATA_W-1:0];  end
      MUL_T2I_A: begin op_a = alpha_re;           op_b = xa_r[DATA_W-1:0];  end
      MUL_T2I_B: begin op_a = alpha_im;           op_b = xa_r[EW-1:DATA_W]; end
      MUL_UR_A:  begin op_a = xb_r[EW-1:DATA_W];  op_b = t1r_r;             end
      MUL_UR_B:  begin op_a = xb_r[DATA_W-1:0];   op_b = t1i_r;             end
      MUL_UR_C:  begin op_a = yb_r[EW-1:DATA_W];  op_b = t2r_r;             end
      MUL_UR_D:  begin op_a = yb_r[DATA_W-1:0];   op_b = t2i_r;             end
      MUL_UI_A:  begin op_a = xb_r[EW-1:DATA_W];  op_b = t1i_r;             end
      MUL_UI_B:  begin op_a = xb_r[DATA_W-1:0];   op_b = t1r_r;             end
      MUL_UI_C:  begin op_a = yb_r[EW-1:DATA_W];  op_b = t2i_r;             end
      MUL_UI_D:  begin op_a = yb_r[DATA_W-1:0];   op_b = t2r_r;             end
      default:   begin op_a = '0;                 op_b = '0;                end
    endcase
  end

  // Step counter and product pipeline register.
  assign step_nxt = q_pop ? 4'd0 : (issue ? step_r + 4'd1 : step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      pv_r   <= 1'b0;
    end else begin
      step_r <= step_nxt;
      pv_r   <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      prod_r <= op_a * op_b;
      tag_r  <= mul_step_t'(step_r);
    end
  end

  // Floor shift of the product by 16; the value fits the accumulator.
  assign prod_sh = prod_r >>> 16;
  assign qv      = prod_sh[ACC_W-1:0];

  // Accumulators, seeded with the incoming element for the update sums.
  always_ff @(posedge clk) begin
    if (q_pop && !q_data.is_load) begin
      t1r_acc <= '0;
      t1i_acc <= '0;
      t2r_acc <= '0;
      t2i_acc <= '0;
      ur_acc  <= ACC_W'(q_data.ap_re);
      ui_acc  <= ACC_W'(q_data.ap_im);
      diag_r  <= q_data.diag;
      last_r  <= q_data.last;
    end else if (pv_r) begin
      unique case (tag_r)
        MUL_T1R_A, MUL_T1R_B: t1r_acc <= t1r_acc + qv;
        MUL_T1I_A:            t1i_acc <= t1i_acc + qv;
        MUL_T1I_B:            t1i_acc <= t1i_acc - qv;
        MUL_T2R_A:            t2r_acc <= t2r_acc + qv;
        MUL_T2R_B:            t2r_acc <= t2r_acc - qv;
        MUL_T2I_A, MUL_T2I_B: t2i_acc <= t2i_acc - qv;
        MUL_UR_A, MUL_UR_C:   ur_acc  <= ur_acc + qv;
        MUL_UR_B, MUL_UR_D:   ur_acc  <= ur_acc - qv;
        default:              ui_acc  <= ui_acc + qv;
      endcase
    end
  end

  // Saturated column factors.
  always_ff @(posedge clk) begin
    if (sat_t) begin
      t1r_r <= sat32(t1r_acc);
      t1i_r <= sat32(t1i_acc);
      t2r_r <= sat32(t2r_acc);
      t2i_r <= sat32(t2i_acc);
    end
  end

  // Result register; the diagonal imaginary part clears unless alpha is zero.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_re_r   <= sat32(ur_acc);
      out_im_r   <= (diag_r && !alpha_zero) ? '0 : sat32(ui_acc);
      out_last_r <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_real           = out_re_r;
  assign out_imag           = out_im_r;
  assign out_last_of_matrix = out_last_r;

endmodule

// ===== rtl/core/hermitian_packed_rank2_update_core.sv =====
// ----------------------------------------------------------------------------
// hermitian_packed_rank2_update_core
// Hermitian packed rank-2 update, A += alpha*x*y^H + conj(alpha)*y*x^H, Q16.16.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): an item with in_mode 0 loads the x and y
// pair at in_vec_index and gives no result. An item with in_mode 1 carries the
// next packed matrix element and gives one result on the output channel
// (out_valid/out_ready) with out_last_of_matrix set on the final element.
// Configuration (cfg_valid/cfg_ready, always ready) sets order, triangle and
// alpha; a write of order or triangle restarts the traversal at column 0.
// When alpha is zero or the column is zero, a matrix element skips the
// multiplies; else one 32x32 multiplier forms the four column factors and
// the four-term update in 16 pipelined products. The back end handles one
// item at a time: it takes the next only once a matrix element's result is
// in the result register; a load is stored as it is popped. A two-entry queue
// lets the front keep accepting while the back end works; when it is full
// in_ready drops. A stalled receiver holds the result register; the back end
// then waits with its next result and the queue fills. Reset clears the queue,
// the sequencer, the position counters and the registers (order 1, upper,
// alpha zero); the vector stores are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module hermitian_packed_rank2_update_core #(
  parameter int MAX_ORDER = hpr2_pkg::DEFAULT_MAX_ORDER
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic [hpr2_pkg::VIDX_W-1:0]          in_vec_index,
  input  logic signed [hpr2_pkg::DATA_W-1:0]   in_x_real,
  input  logic signed [hpr2_pkg::DATA_W-1:0]   in_x_imag,
  input  logic signed [hpr2_pkg::DATA_W-1:0]   in_y_real,
  input  logic signed [hpr2_pkg::DATA_W-1:0]   in_y_imag,
  input  logic signed [hpr2_pkg::DATA_W-1:0]   in_ap_real,
  input  logic signed [hpr2_pkg::DATA_W-1:0]   in_ap_imag,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [hpr2_pkg::DATA_W-1:0]   out_real,
  output logic signed [hpr2_pkg::DATA_W-1:0]   out_imag,
  output logic                                 out_last_of_matrix,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hpr2_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hpr2_pkg::DATA_W-1:0]          cfg_data
);
  import hpr2_pkg::*;

  localparam int IdxW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int QW   = $bits(q_data_t) + 2 * IdxW;

  logic [ORDER_W-1:0]       order_r, order_nxt;
  logic                     upper_r, upper_nxt;
  logic signed [DATA_W-1:0] alpha_re_r, alpha_re_nxt, alpha_im_r, alpha_im_nxt;
  logic                     cfg_we, restart;

  q_data_t         push_data, pop_data;
  logic [IdxW-1:0] push_a, push_b, pop_a, pop_b;
  logic            push_valid, push_ready, pop_valid, pop;
  logic [QW-1:0]   pop_word;

  // Configuration register file.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    order_nxt    = order_r;
    upper_nxt    = upper_r;
    alpha_re_nxt = alpha_re_r;
    alpha_im_nxt = alpha_im_r;
    restart      = 1'b0;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MATRIX_ORDER: begin
          order_nxt = cfg_data[ORDER_W-1:0];
          restart   = 1'b1;
        end
        CFG_UPPER: begin
          upper_nxt = cfg_data[0];
          restart   = 1'b1;
        end
        CFG_ALPHA_RE: alpha_re_nxt = cfg_data;
        CFG_ALPHA_IM: alpha_im_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r    <= ORDER_W'(1);
      upper_r    <= 1'b1;
      alpha_re_r <= '0;
      alpha_im_r <= '0;
    end else begin
      order_r    <= order_nxt;
      upper_r    <= upper_nxt;
      alpha_re_r <= alpha_re_nxt;
      alpha_im_r <= alpha_im_nxt;
    end
  end

  // Front end.
  hpr2_front #(.MAX_ORDER(MAX_ORDER)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_vec_index   (in_vec_index),
    .in_x_real      (in_x_real),
    .in_x_imag      (in_x_imag),
    .in_y_real      (in_y_real),
    .in_y_imag      (in_y_imag),
    .in_ap_real     (in_ap_real),
    .in_ap_imag     (in_ap_imag),
    .matrix_order   (order_r),
    .upper_triangle (upper_r),
    .restart        (restart),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data),
    .push_addr_a    (push_a),
    .push_addr_b    (push_b)
  );

  // Queue between front and back.
  hpr2_queue #(.W(QW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_data, push_a, push_b}),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_word)
  );

  assign {pop_data, pop_a, pop_b} = pop_word;

  // Back end.
  hpr2_back #(.MAX_ORDER(MAX_ORDER)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (pop_valid),
    .q_data             (pop_data),
    .q_addr_a           (pop_a),
    .q_addr_b           (pop_b),
    .q_pop              (pop),
    .alpha_re           (alpha_re_r),
    .alpha_im           (alpha_im_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_real           (out_real),
    .out_imag           (out_imag),
    .out_last_of_matrix (out_last_of_matrix)
  );

endmodule

// ===== rtl/core/hpr2_checker.sv =====
// ----------------------------------------------------------------------------
// hpr2_checker
// Port-level checks of the rank-2 update core, bound to the top level.
// ----------------------------------------------------------------------------
module hpr2_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 in_mode,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [hpr2_pkg::DATA_W-1:0]   out_real,
  input logic signed [hpr2_pkg::DATA_W-1:0]   out_imag,
  input logic                                 out_last_of_matrix,
  input logic                                 cfg_ready
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_real) && $stable(out_imag)
      && $stable(out_last_of_matrix))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The configuration port never pushes back.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

  // An offered input item stays offered, with the same mode, until accepted.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_mode))
    else $error("input item withdrawn before acceptance");

endmodule

bind hermitian_packed_rank2_update_core hpr2_checker u_hpr2_checker (.*);
